@@ rtl/core/ppr_pkg.sv @@
// Shared types, constants and the control store of the path reconstruction block.
package ppr_pkg;

  localparam int unsigned NodeW   = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StepW   = 4;
  localparam int unsigned TableAw = 2 * NodeW;

  localparam logic [CountW-1:0] MaxNodes      = CountW'(64);
  localparam logic [CountW-1:0] NodeCountRst  = CountW'(64);
  localparam logic [CountW-1:0] NoNode        = '1;

  // Control store addresses
  localparam logic [StepW-1:0] StepIdle     = StepW'(0);
  localparam logic [StepW-1:0] StepDispatch = StepW'(1);
  localparam logic [StepW-1:0] StepRange    = StepW'(2);
  localparam logic [StepW-1:0] StepSame     = StepW'(3);
  localparam logic [StepW-1:0] StepPushTgt  = StepW'(4);
  localparam logic [StepW-1:0] StepLoop     = StepW'(5);
  localparam logic [StepW-1:0] StepFull     = StepW'(6);
  localparam logic [StepW-1:0] StepCheck    = StepW'(7);
  localparam logic [StepW-1:0] StepPush     = StepW'(8);
  localparam logic [StepW-1:0] StepPop      = StepW'(9);
  localparam logic [StepW-1:0] StepEmit     = StepW'(10);
  localparam logic [StepW-1:0] StepNext     = StepW'(11);
  localparam logic [StepW-1:0] StepErr      = StepW'(12);
  localparam logic [StepW-1:0] StepSingle   = StepW'(13);
  localparam logic [StepW-1:0] StepWrite    = StepW'(14);

  typedef enum logic [3:0] {
    CondNext,
    CondAlways,
    CondNoStart,
    CondOpWrite,
    CondRangeBad,
    CondSameNode,
    CondAtSource,
    CondDepthFull,
    CondPredBad,
    CondDepthZero
  } cond_e;

  typedef struct packed {
    cond_e            cond;
    logic [StepW-1:0] target;
    logic             load;
    logic             push_tgt;
    logic             rd_pred;
    logic             push_pred;
    logic             pop;
    logic             emit_path;
    logic             emit_single;
    logic             single_err;
    logic             clr_depth;
    logic             wr_pred;
  } ctrl_t;

  typedef struct packed {
    logic op_write;
    logic range_bad;
    logic same_node;
    logic at_source;
    logic depth_full;
    logic pred_bad;
    logic depth_zero;
  } status_t;

  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t w;
    w             = '0;
    w.cond        = CondNext;
    w.target      = StepIdle;
    case (step)
      StepIdle: begin
        w.load   = 1'b1;
        w.cond   = CondNoStart;
        w.target = StepIdle;
      end
      StepDispatch: begin
        w.cond   = CondOpWrite;
        w.target = StepWrite;
      end
      StepRange: begin
        w.cond   = CondRangeBad;
        w.target = StepErr;
      end
      StepSame: begin
        w.cond   = CondSameNode;
        w.target = StepSingle;
      end
      StepPushTgt: begin
        w.push_tgt = 1'b1;
      end
      StepLoop: begin
        w.cond   = CondAtSource;
        w.target = StepPop;
      end
      StepFull: begin
        w.rd_pred = 1'b1;
        w.cond    = CondDepthFull;
        w.target  = StepErr;
      end
      StepCheck: begin
        w.rd_pred = 1'b1;
        w.cond    = CondPredBad;
        w.target  = StepErr;
      end
      StepPush: begin
        w.push_pred = 1'b1;
        w.cond      = CondAlways;
        w.target    = StepLoop;
      end
      StepPop: begin
        w.pop = 1'b1;
      end
      StepEmit: begin
        w.emit_path = 1'b1;
        w.cond      = CondDepthZero;
        w.target    = StepIdle;
      end
      StepNext: begin
        w.cond   = CondAlways;
        w.target = StepPop;
      end
      StepErr: begin
        w.emit_single = 1'b1;
        w.single_err  = 1'b1;
        w.clr_depth   = 1'b1;
        w.cond        = CondAlways;
        w.target      = StepIdle;
      end
      StepSingle: begin
        w.emit_single = 1'b1;
        w.clr_depth   = 1'b1;
        w.cond        = CondAlways;
        w.target      = StepIdle;
      end
      StepWrite: begin
        w.wr_pred = 1'b1;
        w.cond    = CondAlways;
        w.target  = StepIdle;
      end
      default: begin
        w.cond   = CondAlways;
        w.target = StepIdle;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/ppr_seq.sv @@
// Step counter and control store lookup with conditional jumps.
module ppr_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  ppr_pkg::status_t               status_i,
  output ppr_pkg::ctrl_t                 ctrl_o,
  output logic                           busy
);

  logic [ppr_pkg::StepW-1:0] pc_q, pc_d;
  ppr_pkg::ctrl_t            ctrl;
  logic                      take;

  assign ctrl   = ppr_pkg::ucode(pc_q);
  assign ctrl_o = ctrl;
  assign busy   = (pc_q != ppr_pkg::StepIdle);

  always_comb begin
    case (ctrl.cond)
      ppr_pkg::CondNext:      take = 1'b0;
      ppr_pkg::CondAlways:    take = 1'b1;
      ppr_pkg::CondNoStart:   take = !start;
      ppr_pkg::CondOpWrite:   take = status_i.op_write;
      ppr_pkg::CondRangeBad:  take = status_i.range_bad;
      ppr_pkg::CondSameNode:  take = status_i.same_node;
      ppr_pkg::CondAtSource:  take = status_i.at_source;
      ppr_pkg::CondDepthFull: take = status_i.depth_full;
      ppr_pkg::CondPredBad:   take = status_i.pred_bad;
      ppr_pkg::CondDepthZero: take = status_i.depth_zero;
      default:                take = 1'b1;
    endcase
    pc_d = take ? ctrl.target : pc_q + ppr_pkg::StepW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ppr_pkg::StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ rtl/core/ppr_datapath.sv @@
// Predecessor table, path stack, walk registers and result word register.
module ppr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  ppr_pkg::ctrl_t                ctrl_i,
  input  logic                          cfg_we_i,
  input  logic [ppr_pkg::CountW-1:0]    cfg_wdata_i,
  input  logic                          operation_i,
  input  logic [ppr_pkg::NodeW-1:0]     source_node_i,
  input  logic [ppr_pkg::NodeW-1:0]     target_node_i,
  input  logic [ppr_pkg::NodeW-1:0]     predecessor_value_i,
  output ppr_pkg::status_t              status_o,
  output logic                          result_strobe_o,
  output logic signed [ppr_pkg::CountW-1:0] path_node_o,
  output logic                          last_node_o,
  output logic                          walk_error_o
);

  localparam int unsigned TableDepth = 1 << ppr_pkg::TableAw;
  localparam int unsigned StackDepth = 1 << ppr_pkg::NodeW;

  logic [ppr_pkg::NodeW-1:0] pred_mem  [TableDepth];
  logic [ppr_pkg::NodeW-1:0] stack_mem [StackDepth];

  logic [ppr_pkg::CountW-1:0] node_count_q;
  logic [ppr_pkg::CountW-1:0] depth_q, depth_d;
  logic [ppr_pkg::CountW-1:0] n_eff;
  logic [ppr_pkg::CountW-1:0] depth_dec;
  logic                       op_q;
  logic [ppr_pkg::NodeW-1:0]  src_q, tgt_q, val_q, cur_q;
  logic [ppr_pkg::NodeW-1:0]  pred_rdata_q, stack_rdata_q;
  logic                       stack_we;
  logic [ppr_pkg::NodeW-1:0]  stack_wdata;
  logic                       pred_we;
  logic                       strobe_q;
  logic [ppr_pkg::CountW-1:0] path_q;
  logic                       last_q, err_q;

  assign n_eff     = (node_count_q > ppr_pkg::MaxNodes) ? ppr_pkg::MaxNodes : node_count_q;
  assign depth_dec = depth_q - ppr_pkg::CountW'(1);

  assign status_o.op_write   = !op_q;
  assign status_o.range_bad  = ({1'b0, src_q} >= n_eff) || ({1'b0, tgt_q} >= n_eff);
  assign status_o.same_node  = (src_q == tgt_q);
  assign status_o.at_source  = (cur_q == src_q);
  assign status_o.depth_full = (depth_q >= n_eff);
  assign status_o.pred_bad   = ({1'b0, pred_rdata_q} >= n_eff);
  assign status_o.depth_zero = (depth_q == '0);

  assign stack_we    = ctrl_i.push_tgt || ctrl_i.push_pred;
  assign stack_wdata = ctrl_i.push_tgt ? tgt_q : pred_rdata_q;
  assign pred_we     = ctrl_i.wr_pred && !status_o.range_bad;

  always_comb begin
    depth_d = depth_q;
    if (ctrl_i.clr_depth) begin
      depth_d = '0;
    end else if (stack_we) begin
      depth_d = depth_q + ppr_pkg::CountW'(1);
    end else if (ctrl_i.pop) begin
      depth_d = depth_dec;
    end
  end

  // Control and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= ppr_pkg::NodeCountRst;
      depth_q      <= '0;
      strobe_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      depth_q  <= depth_d;
      strobe_q <= ctrl_i.emit_path || ctrl_i.emit_single;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && start) begin
      op_q  <= operation_i;
      src_q <= source_node_i;
      tgt_q <= target_node_i;
      val_q <= predecessor_value_i;
    end
    if (ctrl_i.push_tgt) begin
      cur_q <= tgt_q;
    end else if (ctrl_i.push_pred) begin
      cur_q <= pred_rdata_q;
    end
    if (ctrl_i.emit_single) begin
      path_q <= ppr_pkg::NoNode;
      last_q <= 1'b1;
      err_q  <= ctrl_i.single_err;
    end else if (ctrl_i.emit_path) begin
      path_q <= {1'b0, stack_rdata_q};
      last_q <= (depth_q == '0);
      err_q  <= 1'b0;
    end
  end

  // Predecessor table: entry address is source then node
  always_ff @(posedge clk_i) begin
    if (pred_we) begin
      pred_mem[{src_q, tgt_q}] <= val_q;
    end
    if (ctrl_i.rd_pred) begin
      pred_rdata_q <= pred_mem[{src_q, cur_q}];
    end
  end

  // Path stack
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[depth_q[ppr_pkg::NodeW-1:0]] <= stack_wdata;
    end
    if (ctrl_i.pop) begin
      stack_rdata_q <= stack_mem[depth_dec[ppr_pkg::NodeW-1:0]];
    end
  end

  assign result_strobe_o = strobe_q;
  assign path_node_o     = path_q;
  assign last_node_o     = last_q;
  assign walk_error_o    = err_q;

endmodule

@@ rtl/core/predecessor_path_reconstruct.sv @@
// Top level of the shortest path reconstruction block.
//
// Holds a 64 x 64 predecessor table (entry for source s and node t gives the
// node before t on the shortest path from s) and answers path queries. A word
// is taken at a clock edge with start high and busy low. A write word
// (operation 0) stores one entry and gives no result; it is dropped when
// source or target is at or beyond node_count. A query word (operation 1)
// walks the predecessors back from the target to the source, stacks the
// nodes, then emits the path from source to target, one node per result word,
// with last_node_o set on the final one. Target equal to source gives one
// word of -1. An index out of range, a stored predecessor out of range, or a
// walk longer than node_count gives one word of -1 with walk_error_o set.
// Each result is shown for exactly one cycle with result_strobe_o high; the
// receiver cannot stall, so capture it then. Control is a short microprogram
// stepped by a counter. A query walks back one hop per pass through its loop
// steps, with a registered table read on each hop, then unloads the stack one
// node per pass, one result word each; an error found during the walk is
// reported only after the walk up to that point, and the stack is then cleared.
// node_count resets to 64 and should be written only while busy is low.
// Reading a table entry that was never written gives an undefined node.
module predecessor_path_reconstruct (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we_i,
  input  logic [ppr_pkg::CountW-1:0]        cfg_wdata_i,
  input  logic                              operation_i,
  input  logic [ppr_pkg::NodeW-1:0]         source_node_i,
  input  logic [ppr_pkg::NodeW-1:0]         target_node_i,
  input  logic [ppr_pkg::NodeW-1:0]         predecessor_value_i,
  output logic                              result_strobe_o,
  output logic signed [ppr_pkg::CountW-1:0] path_node_o,
  output logic                              last_node_o,
  output logic                              walk_error_o
);

  ppr_pkg::ctrl_t   ctrl;
  ppr_pkg::status_t status;

  // Sequencer: step counter plus control store
  ppr_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy     (busy)
  );

  // Datapath: table, stack, walk registers, result word
  ppr_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .ctrl_i              (ctrl),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .operation_i         (operation_i),
    .source_node_i       (source_node_i),
    .target_node_i       (target_node_i),
    .predecessor_value_i (predecessor_value_i),
    .status_o            (status),
    .result_strobe_o     (result_strobe_o),
    .path_node_o         (path_node_o),
    .last_node_o         (last_node_o),
    .walk_error_o        (walk_error_o)
  );

endmodule

@@ tb/predecessor_path_reconstruct_checker.sv @@
// Shared testbench types and the scoreboard that predicts and checks path result words.
`timescale 1ns / 1ps

package ppr_tb_pkg;

  typedef enum logic {
    OpWrite = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [ppr_pkg::CountW-1:0] node;
    logic                              last;
    logic                              err;
  } path_word_t;

endpackage

module predecessor_path_reconstruct_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              cfg_we_i,
  input  logic [ppr_pkg::CountW-1:0]        cfg_wdata_i,
  input  logic                              operation_i,
  input  logic [ppr_pkg::NodeW-1:0]         source_node_i,
  input  logic [ppr_pkg::NodeW-1:0]         target_node_i,
  input  logic [ppr_pkg::NodeW-1:0]         predecessor_value_i,
  input  logic                              result_strobe_i,
  input  logic signed [ppr_pkg::CountW-1:0] path_node_i,
  input  logic                              last_node_i,
  input  logic                              walk_error_i,
  output int                                mismatch_count_o,
  output int                                waiting_count_o,
  output int                                words_checked_o,
  output int                                single_words_o
);
  import ppr_tb_pkg::*;

  localparam int unsigned Nodes     = 64;
  localparam int unsigned ReportCap = 10;

  logic [ppr_pkg::NodeW-1:0]  pred_mem [Nodes][Nodes];
  logic [ppr_pkg::CountW-1:0] count_reg;
  path_word_t                 path_words_due [$];
  int                         mismatches;
  int                         words;
  int                         singles;

  function automatic int unsigned nodes_in_use();
    return (count_reg > Nodes) ? Nodes : int'(count_reg);
  endfunction

  // Append one expected word at the tail of the queue.
  function automatic void queue_word(input path_word_t w);
    path_words_due = {path_words_due, w};
  endfunction

  function automatic void queue_single(input logic err);
    path_word_t w;
    w.node = ppr_pkg::NoNode;
    w.last = 1'b1;
    w.err  = err;
    queue_word(w);
  endfunction

  // Work out every result word that one accepted word causes.
  function automatic void predict_path(input op_e op, input logic [ppr_pkg::NodeW-1:0] src,
                                       input logic [ppr_pkg::NodeW-1:0] tgt,
                                       input logic [ppr_pkg::NodeW-1:0] pv);
    logic [ppr_pkg::NodeW-1:0] hops [Nodes];
    logic [ppr_pkg::NodeW-1:0] cur;
    logic [ppr_pkg::NodeW-1:0] p;
    int unsigned               n;
    int unsigned               depth;
    path_word_t                w;
    n = nodes_in_use();
    if (op == OpWrite) begin
      if (src < n && tgt < n) pred_mem[src][tgt] = pv;
      return;
    end
    if (src >= n || tgt >= n) begin
      queue_single(1'b1);
      return;
    end
    if (src == tgt) begin
      queue_single(1'b0);
      return;
    end
    hops[0] = tgt;
    depth   = 1;
    cur     = tgt;
    while (cur != src) begin
      if (depth >= n) begin
        queue_single(1'b1);
        return;
      end
      p = pred_mem[src][cur];
      if (p >= n) begin
        queue_single(1'b1);
        return;
      end
      hops[depth] = p;
      depth++;
      cur = p;
    end
    // Unstack: source first, target last and marked.
    for (int k = int'(depth) - 1; k >= 0; k--) begin
      w.node = {1'b0, hops[k]};
      w.last = (k == 0);
      w.err  = 1'b0;
      queue_word(w);
    end
  endfunction

  always @(posedge clk_i) begin : watch
    path_word_t due;
    if (!rst_ni) begin
      count_reg = ppr_pkg::NodeCountRst;
      path_words_due.delete();
    end else begin
      if (cfg_we_i) count_reg = cfg_wdata_i;
      if (start && !busy) begin
        predict_path(op_e'(operation_i), source_node_i, target_node_i, predecessor_value_i);
      end
      if (result_strobe_i !== 1'b0) begin
        if (path_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportCap) begin
            $display("%0t: unexpected result word: node %0d last %0b err %0b",
                     $time, path_node_i, last_node_i, walk_error_i);
          end
        end else begin
          due = path_words_due.pop_front();
          words++;
          if (due.last && due.node == ppr_pkg::NoNode) singles++;
          if (path_node_i !== due.node || last_node_i !== due.last ||
              walk_error_i !== due.err) begin
            mismatches++;
            if (mismatches <= ReportCap) begin
              $display("%0t: result word mismatch: expected node %0d last %0b err %0b,",
                       $time, due.node, due.last, due.err);
              $display("    got node %0d last %0b err %0b",
                       path_node_i, last_node_i, walk_error_i);
            end
          end
        end
      end
    end
    waiting_count_o  <= path_words_due.size();
    mismatch_count_o <= mismatches;
    words_checked_o  <= words;
    single_words_o   <= singles;
  end

endmodule

@@ tb/predecessor_path_reconstruct_tb.sv @@
// Stimulus and verdict for the predecessor path reconstruction block.
`timescale 1ns / 1ps

module predecessor_path_reconstruct_tb;
  import ppr_tb_pkg::*;

  localparam int unsigned Nodes       = 64;
  localparam int unsigned RandomWords = 260;
  // Slowest honest run: every word at its longest plus sender gaps stays well
  // under this limit; leave plenty of room on top.
  localparam longint      CycleLimit  = 1_000_000;
  // Writes give no result word; let a trailing write settle before config.
  localparam int unsigned ConfigHold  = 8;
  localparam int unsigned DrainCycles = 64;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic                              cfg_we_i;
  logic [ppr_pkg::CountW-1:0]        cfg_wdata_i;
  logic                              operation_i;
  logic [ppr_pkg::NodeW-1:0]         source_node_i;
  logic [ppr_pkg::NodeW-1:0]         target_node_i;
  logic [ppr_pkg::NodeW-1:0]         predecessor_value_i;
  logic                              result_strobe_o;
  logic signed [ppr_pkg::CountW-1:0] path_node_o;
  logic                              last_node_o;
  logic                              walk_error_o;

  int mismatch_count;
  int waiting_count;
  int words_checked;
  int single_words;

  // Stimulus-side copy of what has been loaded, used only to keep every walk
  // on entries that were actually written since reset.
  logic [ppr_pkg::NodeW-1:0] plan_pred  [Nodes][Nodes];
  bit                        plan_known [Nodes][Nodes];
  int unsigned               active_count = Nodes;

  int unsigned writes_sent;
  int unsigned queries_sent;
  int unsigned items_sent;
  int unsigned settings_used;
  bit          steady;
  longint      cycles;

  always #5ns clk_i = ~clk_i;

  predecessor_path_reconstruct dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .operation_i         (operation_i),
    .source_node_i       (source_node_i),
    .target_node_i       (target_node_i),
    .predecessor_value_i (predecessor_value_i),
    .result_strobe_o     (result_strobe_o),
    .path_node_o         (path_node_o),
    .last_node_o         (last_node_o),
    .walk_error_o        (walk_error_o)
  );

  predecessor_path_reconstruct_checker path_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .operation_i         (operation_i),
    .source_node_i       (source_node_i),
    .target_node_i       (target_node_i),
    .predecessor_value_i (predecessor_value_i),
    .result_strobe_i     (result_strobe_o),
    .path_node_i         (path_node_o),
    .last_node_i         (last_node_o),
    .walk_error_i        (walk_error_o),
    .mismatch_count_o    (mismatch_count),
    .waiting_count_o     (waiting_count),
    .words_checked_o     (words_checked),
    .single_words_o      (single_words)
  );

  // Hard stop if the block hangs or loses words.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // True when a query walk would only touch written entries. Range errors
  // and same-node queries never read the table. Check the entry of the
  // current node before the depth test, since the walk may fetch it anyway.
  function automatic bit walk_known(input logic [ppr_pkg::NodeW-1:0] src,
                                    input logic [ppr_pkg::NodeW-1:0] tgt);
    logic [ppr_pkg::NodeW-1:0] cur;
    logic [ppr_pkg::NodeW-1:0] p;
    int unsigned               depth;
    if (src >= active_count || tgt >= active_count || src == tgt) return 1'b1;
    cur   = tgt;
    depth = 1;
    while (cur != src) begin
      if (!plan_known[src][cur]) return 1'b0;
      if (depth >= active_count) return 1'b1;
      p = plan_pred[src][cur];
      if (p >= active_count) return 1'b1;
      depth++;
      cur = p;
    end
    return 1'b1;
  endfunction

  // Present one word, hold it until taken, then idle for a random gap.
  task automatic send_word(input op_e op, input logic [ppr_pkg::NodeW-1:0] src,
                           input logic [ppr_pkg::NodeW-1:0] tgt,
                           input logic [ppr_pkg::NodeW-1:0] pv);
    int unsigned gap;
    int unsigned r;
    start               <= 1'b1;
    operation_i         <= op;
    source_node_i       <= src;
    target_node_i       <= tgt;
    predecessor_value_i <= pv;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
    if (op == OpWrite) begin
      writes_sent++;
      if (src < active_count && tgt < active_count) begin
        plan_pred[src][tgt]  = pv;
        plan_known[src][tgt] = 1'b1;
      end
    end else begin
      queries_sent++;
    end
    // Mostly short gaps, a few long ones; none at all during steady stretches.
    r = $urandom_range(0, 99);
    if (steady || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Query a path; fall back to a same-node query if the walk would hit
  // an entry that was never loaded.
  task automatic ask(input logic [ppr_pkg::NodeW-1:0] src,
                     input logic [ppr_pkg::NodeW-1:0] tgt);
    if (!walk_known(src, tgt)) tgt = src;
    send_word(OpQuery, src, tgt, ppr_pkg::NodeW'($urandom_range(0, Nodes - 1)));
  endtask

  // Drain the block, then write node_count.
  task automatic set_count(input logic [ppr_pkg::CountW-1:0] value);
    start <= 1'b0;
    do @(posedge clk_i); while (busy !== 1'b0 || waiting_count != 0);
    repeat (ConfigHold) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    active_count  = (value > Nodes) ? Nodes : value;
    settings_used++;
  endtask

  // Load a fresh chain source -> v0 -> v1 ... for one source, sometimes
  // break it (loop or bad predecessor), then ask for paths along it.
  task automatic build_path();
    logic [ppr_pkg::NodeW-1:0] chain [Nodes];
    logic [ppr_pkg::NodeW-1:0] s;
    logic [ppr_pkg::NodeW-1:0] prev;
    logic [ppr_pkg::NodeW-1:0] tmp;
    int unsigned               n;
    int unsigned               m;
    int unsigned               len;
    int unsigned               i;
    int unsigned               j;
    int unsigned               r;
    n = active_count;
    if (n < 2) begin
      ask(0, 0);
      return;
    end
    s = ppr_pkg::NodeW'($urandom_range(0, n - 1));
    m = 0;
    for (i = 0; i < n; i++) begin
      if (i != s) begin
        chain[m] = ppr_pkg::NodeW'(i);
        m++;
      end
    end
    // Short chains mostly, now and then one of any length up to n nodes.
    if ($urandom_range(0, 11) == 0) len = $urandom_range(1, n - 1);
    else len = $urandom_range(1, (n - 1 < 6) ? n - 1 : 6);
    for (i = 0; i < len; i++) begin
      j        = $urandom_range(i, m - 1);
      tmp      = chain[i];
      chain[i] = chain[j];
      chain[j] = tmp;
    end
    steady = ($urandom_range(0, 3) == 0);
    prev   = s;
    for (i = 0; i < len; i++) begin
      send_word(OpWrite, s, chain[i], prev);
      prev = chain[i];
    end
    r = $urandom_range(0, 5);
    if (r == 0) begin
      // Point a link back down the chain: the walk then loops until the depth check ends it.
      i = $urandom_range(0, len - 1);
      j = $urandom_range(i, len - 1);
      send_word(OpWrite, s, chain[i], chain[j]);
    end else if (r == 1 && n < Nodes) begin
      send_word(OpWrite, s, chain[$urandom_range(0, len - 1)],
                ppr_pkg::NodeW'($urandom_range(n, Nodes - 1)));
    end
    ask(s, chain[len - 1]);
    repeat ($urandom_range(0, 2)) ask(s, chain[$urandom_range(0, len - 1)]);
  endtask

  initial begin
    logic [ppr_pkg::CountW-1:0] phase_counts [6];
    int unsigned                goal;
    start               <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= ppr_pkg::NodeCountRst;
    operation_i         <= OpWrite;
    source_node_i       <= '0;
    target_node_i       <= '0;
    predecessor_value_i <= '0;
    rst_ni              <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset node count of 64.
    ask(0, 0);                        // same node at the low corner
    ask(63, 63);                      // same node at the high corner
    send_word(OpWrite, 0, 63, 0);
    ask(0, 63);                       // one hop, extreme nodes
    send_word(OpWrite, 63, 0, 63);
    send_word(OpWrite, 63, 62, 0);
    ask(63, 62);                      // two hops
    send_word(OpWrite, 21, 42, 42);
    ask(21, 42);                      // entry pointing at itself: overlong walk
    send_word(OpWrite, 42, 1, 2);
    send_word(OpWrite, 42, 2, 1);
    ask(42, 1);                       // two-node loop: overlong walk

    // Small node count: range errors, dropped writes, bad stored predecessor.
    set_count(8);
    ask(0, 63);                       // target out of range
    ask(63, 0);                       // source out of range
    send_word(OpWrite, 9, 1, 0);      // dropped: source out of range
    send_word(OpWrite, 3, 5, 60);
    ask(3, 5);                        // stored predecessor beyond node count
    send_word(OpWrite, 7, 6, 7);
    ask(7, 6);                        // highest node in range
    send_word(OpWrite, 1, 2, 1);
    ask(1, 2);

    // Single node: only the same-node answer or a range error exists.
    set_count(1);
    ask(0, 0);
    ask(0, 1);

    // Random part: several node counts, most of the words in well-formed
    // chains with random content, the rest noise.
    phase_counts = '{64, 2, 7'($urandom_range(3, 63)), 1, 37, 64};
    goal = items_sent;
    foreach (phase_counts[p]) begin
      set_count(phase_counts[p]);
      goal += (phase_counts[p] == 1) ? 10 : (RandomWords - 60) / 5;
      while (items_sent < goal) begin
        if ($urandom_range(0, 9) < 7) begin
          build_path();
        end else if ($urandom_range(0, 1) == 1) begin
          send_word(OpWrite, ppr_pkg::NodeW'($urandom_range(0, Nodes - 1)),
                    ppr_pkg::NodeW'($urandom_range(0, Nodes - 1)),
                    ppr_pkg::NodeW'($urandom_range(0, Nodes - 1)));
        end else begin
          ask(ppr_pkg::NodeW'($urandom_range(0, Nodes - 1)),
              ppr_pkg::NodeW'($urandom_range(0, Nodes - 1)));
        end
      end
    end

    // Wait for every expected word, then watch a while for strays.
    start <= 1'b0;
    do @(posedge clk_i); while (busy !== 1'b0 || waiting_count != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d writes and %0d path queries over %0d node_count settings.",
             writes_sent, queries_sent, settings_used);
    $display("Checked %0d result words, %0d of them single -1 answers; %0d mismatches.",
             words_checked, single_words, mismatch_count);
    if (mismatch_count == 0 && waiting_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ppr_pkg.sv
rtl/core/ppr_seq.sv
rtl/core/ppr_datapath.sv
rtl/core/predecessor_path_reconstruct.sv
tb/predecessor_path_reconstruct_checker.sv
tb/predecessor_path_reconstruct_tb.sv
